// ----- sv/ffl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_pkg: shared definitions for the fixed pool free list
// Pool geometry, request and status codes, controller states and commands.
// ----------------------------------------------------------------------------
package ffl_pkg;

   localparam int POOL_SIZE = 256;
   localparam int LINK_W    = $clog2(POOL_SIZE);
   localparam int IDX_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int WIDE_W    = ((LINK_W > IDX_W) ? LINK_W : IDX_W) + 1;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_COMMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ----- sv/ffl_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_req_if: request channel
// Valid/ready channel carrying one allocate or free request per item.
// ----------------------------------------------------------------------------
interface ffl_req_if
   import ffl_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic             kind;
   logic [IDX_W-1:0] slot_index;

   modport source (output valid, output kind, output slot_index, input ready);
   modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

// ----- sv/ffl_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_rsp_if: response channel
// Valid/ready channel carrying one status and granted slot per item.
// ----------------------------------------------------------------------------
interface ffl_rsp_if
   import ffl_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

// ----- sv/ffl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ram: generic simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ffl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_ctrl: free list controller
// Sequences link lookup and commit, and owns the response valid flag.
// ----------------------------------------------------------------------------
module ffl_ctrl
   import ffl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_to_commit: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_COMMIT)
      else $error("accepted item did not move to commit");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("commit did not present a response");

   a_stall_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT && !cmd.commit |-> rsp_valid_ff && !rsp_ready)
      else $error("commit held back without a stalled response");
`endif

endmodule

// ----- sv/ffl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffl_dp: free list datapath
// Head register, link ram with per-entry written flags, and result registers.
// ----------------------------------------------------------------------------
module ffl_dp
   import ffl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                req_kind,
   input  logic [IDX_W-1:0]    req_slot_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_granted_index
);

   kind_type            kind_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [POOL_SIZE-1:0] written_ff, written_in;
   logic                hit_ff;
   status_type          status_ff, status_in;
   logic [IDX_W-1:0]    granted_ff, granted_in;

   logic [LINK_W-1:0]   rd_link;
   logic [LINK_W-1:0]   reset_link;
   logic [LINK_W-1:0]   link;
   logic                head_ok;
   logic                idx_ok;
   logic                is_alloc;
   logic                wr_en;
   logic [LINK_W-1:0]   wr_addr;
   logic [LINK_W-1:0]   wr_data;

   ffl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_SIZE)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (head_ff),
      .rd_data (rd_link)
   );

   // unwritten entries hold their reset link
   assign reset_link = (head_ff == LINK_W'(POOL_SIZE - 1)) ? '0 : head_ff + 1'b1;
   assign link       = hit_ff ? rd_link : reset_link;

   assign is_alloc = (kind_ff == KIND_ALLOC);
   assign head_ok  = (head_ff != '0) && (WIDE_W'(head_ff) < WIDE_W'(POOL_SIZE));
   assign idx_ok   = (idx_ff != '0) && (WIDE_W'(idx_ff) < WIDE_W'(POOL_SIZE));

   assign wr_en   = cmd.commit && (is_alloc ? head_ok : idx_ok);
   assign wr_addr = is_alloc ? head_ff : LINK_W'(idx_ff);
   assign wr_data = is_alloc ? '0 : head_ff;

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      head_in    = head_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      if (cmd.commit) begin
         granted_in = '0;
         if (is_alloc) begin
            if (head_ok) begin
               head_in    = link;
               status_in  = ST_OK;
               granted_in = IDX_W'(head_ff);
            end else begin
               status_in = ST_EXHAUSTED;
            end
         end else begin
            if (idx_ok) begin
               head_in   = LINK_W'(idx_ff);
               status_in = ST_OK;
            end else begin
               status_in = ST_BAD_INDEX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= LINK_W'(1);
         written_ff <= '0;
      end else begin
         head_ff    <= head_in;
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         idx_ff  <= req_slot_index;
         hit_ff  <= written_ff[head_ff];
      end
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;

endmodule

// ----- sv/fixed_pool_free_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_pool_free_list: lifo free list allocator for a fixed slot pool
// Slot 0 is the null link and is never handed out; slots are handed out and
// returned at the head.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per item: kind 0 allocates, kind 1 returns
//   slot_index to the pool. rsp_ch returns one item per request with status
//   (ok, exhausted, invalid index) and the granted slot on a good allocate.
//   A request accepted in idle has its link read from the link ram; then in
//   commit, once the output register is free, it updates the head and loads
//   its response. A new request is taken only after the last has committed.
//   The response sits in an output register; req_ready is low in the commit
//   cycle of every item and stays low while a finished item waits for that
//   register. If rsp_ch stalls, one response is held and one more request
//   is taken and kept in commit until the response is taken.
//   Reset (synchronous) empties the response register and returns the pool
//   to its initial list, every slot linked to the next, at once: written
//   flags per link entry stand in for the initial contents, so no clearing
//   pass is needed and a request may be sent in the first cycle after reset.
// ----------------------------------------------------------------------------
module fixed_pool_free_list
   import ffl_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ffl_req_if.sink   req_ch,
   ffl_rsp_if.source rsp_ch
);

   cmd_type cmd;

   ffl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   ffl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_ch.kind),
      .req_slot_index    (req_ch.slot_index),
      .rsp_status        (rsp_ch.status),
      .rsp_granted_index (rsp_ch.granted_index)
   );

endmodule
